@@ sv/sbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_pkg: shared types for the stack bytecode executor
// Opcodes, error codes, decoded-op kinds and the beat payload structs.
// ----------------------------------------------------------------------------
package sbe_pkg;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_PRINT = 3'd1,
    OP_READ  = 3'd2,
    OP_ADD   = 3'd3,
    OP_STOP  = 3'd4
  } sbe_opcode_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_PRINT_EMPTY   = 3'd1,
    ERR_BAD_INPUT     = 3'd2,
    ERR_ADD_UNDERFLOW = 3'd3,
    ERR_UNKNOWN_OP    = 3'd4,
    ERR_OVERFLOW      = 3'd5
  } sbe_err_e;

  // Decoded op as handed from the front end to the execute stage
  typedef enum logic [2:0] {
    KIND_PUSH,
    KIND_PRINT,
    KIND_ADD,
    KIND_BAD_READ,
    KIND_STOP,
    KIND_UNKNOWN,
    KIND_IGNORED
  } sbe_kind_e;

  typedef enum logic {
    ST_EXEC,
    ST_FIX
  } sbe_state_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [63:0] argument;
    logic signed [63:0] read_value;
    logic               read_ok;
  } sbe_in_t;

  typedef struct packed {
    logic               print_valid;
    logic signed [63:0] print_value;
    logic [2:0]         error_code;
    logic               is_halted;
  } sbe_out_t;

  typedef struct packed {
    sbe_kind_e          kind;
    logic signed [63:0] value;
  } sbe_op_t;

  typedef struct packed {
    logic issue;
    logic fix;
  } sbe_exec_status_t;

endpackage

@@ sv/sbe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_front: instruction intake
// Decodes each input beat into an op kind, tracks the halt flag and buffers
// decoded ops in a two-entry queue toward the execute stage.
// ----------------------------------------------------------------------------
module sbe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  sbe_pkg::sbe_in_t in_data_i,
  output logic            op_valid_o,
  output sbe_pkg::sbe_op_t op_o,
  input  logic            op_deq_i,
  output logic            halted_o
);
  import sbe_pkg::*;

  sbe_op_t    q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       halted_q, halted_d;
  logic       accept;
  sbe_op_t    dec;

  assign full   = (cnt_q == 2'd2);
  assign accept = push && !full;

  always_comb begin
    dec.value = in_data_i.argument;
    dec.kind  = KIND_IGNORED;
    halted_d  = halted_q;
    if (!halted_q) begin
      case (sbe_opcode_e'(in_data_i.command))
        OP_PUSH:  dec.kind = KIND_PUSH;
        OP_PRINT: dec.kind = KIND_PRINT;
        OP_READ: begin
          dec.value = in_data_i.read_value;
          dec.kind  = in_data_i.read_ok ? KIND_PUSH : KIND_BAD_READ;
        end
        OP_ADD:   dec.kind = KIND_ADD;
        OP_STOP: begin
          dec.kind = KIND_STOP;
          if (accept) halted_d = 1'b1;
        end
        default: begin
          dec.kind = KIND_UNKNOWN;
          if (accept) halted_d = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ accept;
    rd_ptr_d = rd_ptr_q ^ op_deq_i;
    cnt_d    = cnt_q + {1'b0, accept} - {1'b0, op_deq_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      halted_q <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) q_mem[wr_ptr_q] <= dec;
  end

  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = q_mem[rd_ptr_q];
  assign halted_o   = halted_q;

endmodule

@@ sv/sbe_exec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbe_exec: execute stage
// Runs decoded ops against the stack (top word in a register, the rest in a
// RAM with a registered read port) and queues results in a two-entry buffer.
// ----------------------------------------------------------------------------
module sbe_exec #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      op_valid_i,
  input  sbe_pkg::sbe_op_t          op_i,
  output logic                      op_deq_o,
  output logic                      empty,
  input  logic                      pop,
  output sbe_pkg::sbe_out_t         out_data_o,
  output sbe_pkg::sbe_exec_status_t status_o
);
  import sbe_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam logic [LW-1:0] LvlFull = LW'(STACK_DEPTH);
  localparam logic [LW-1:0] LvlOne  = LW'(1);
  localparam logic [LW-1:0] LvlTwo  = LW'(2);

  logic signed [63:0] stk_mem [STACK_DEPTH];
  logic signed [63:0] rdata_q;
  logic signed [63:0] top_q, top_d;
  logic [LW-1:0]      level_q, level_d;
  logic [LW-1:0]      level_m1, level_m2;
  sbe_state_e         state_q, state_d;
  logic               fix_add_q, fix_add_d;
  logic               wr_en, rd_en;
  logic               issue;

  sbe_out_t   res;
  sbe_out_t   res_mem [2];
  logic       res_wr_q, res_rd_q;
  logic [1:0] res_cnt_q;
  logic       res_pop;

  assign level_m1 = level_q - LvlOne;
  assign level_m2 = level_q - LvlTwo;
  assign issue    = op_valid_i && (state_q == ST_EXEC) && (res_cnt_q != 2'd2);
  assign op_deq_o = issue;
  assign res_pop  = pop && !empty;

  always_comb begin
    level_d   = level_q;
    top_d     = top_q;
    state_d   = state_q;
    fix_add_d = fix_add_q;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    res       = '0;
    case (state_q)
      ST_FIX: begin
        top_d   = fix_add_q ? (top_q + rdata_q) : rdata_q;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (issue) begin
          case (op_i.kind)
            KIND_PUSH: begin
              if (level_q == LvlFull) begin
                res.error_code = ERR_OVERFLOW;
              end else begin
                wr_en   = (level_q != '0);
                top_d   = op_i.value;
                level_d = level_q + LvlOne;
              end
            end
            KIND_PRINT: begin
              if (level_q == '0) begin
                res.error_code = ERR_PRINT_EMPTY;
              end else begin
                res.print_valid = 1'b1;
                res.print_value = top_q;
                level_d         = level_m1;
                if (level_q >= LvlTwo) begin
                  rd_en     = 1'b1;
                  fix_add_d = 1'b0;
                  state_d   = ST_FIX;
                end
              end
            end
            KIND_ADD: begin
              if (level_q >= LvlTwo) begin
                rd_en     = 1'b1;
                fix_add_d = 1'b1;
                state_d   = ST_FIX;
                level_d   = level_m1;
              end else begin
                res.error_code = ERR_ADD_UNDERFLOW;
                level_d        = '0;
              end
            end
            KIND_BAD_READ: res.error_code = ERR_BAD_INPUT;
            KIND_STOP:     res.is_halted  = 1'b1;
            KIND_UNKNOWN: begin
              res.error_code = ERR_UNKNOWN_OP;
              res.is_halted  = 1'b1;
            end
            KIND_IGNORED:  res.is_halted  = 1'b1;
            default:       res = '0;
          endcase
        end
      end
      default: state_d = ST_EXEC;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) stk_mem[level_m1[AW-1:0]] <= top_q;
    if (rd_en) rdata_q <= stk_mem[level_m2[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (issue) res_mem[res_wr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= '0;
      state_q   <= ST_EXEC;
      fix_add_q <= 1'b0;
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      level_q   <= level_d;
      state_q   <= state_d;
      fix_add_q <= fix_add_d;
      res_wr_q  <= res_wr_q ^ issue;
      res_rd_q  <= res_rd_q ^ res_pop;
      res_cnt_q <= res_cnt_q + {1'b0, issue} - {1'b0, res_pop};
    end
  end

  assign empty          = (res_cnt_q == 2'd0);
  assign out_data_o     = res_mem[res_rd_q];
  assign status_o.issue = issue;
  assign status_o.fix   = (state_q == ST_FIX);

endmodule

@@ sv/stack_bytecode_executor_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bytecode_executor_unit: stack-machine bytecode executor
// One instruction per input beat, one result beat per instruction.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------
//   input    | push / full        | in_data_i  (command, argument, read_value, read_ok)
//   result   | pop / empty        | out_data_o (print_valid, print_value, error_code,
//            |                    |             is_halted)
//
// Print or add with two or more words held passes through a fix state that
// reloads the top-of-stack register from the stack RAM's registered read port;
// no new instruction issues while in it, and other instructions skip it.
// Two-entry queues on each side of execute; either side may stall alone.
// Reset clears control state only; stack RAM is not cleared (no sweep).
// ----------------------------------------------------------------------------
module stack_bytecode_executor_unit #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  sbe_pkg::sbe_in_t  in_data_i,
  output logic              empty,
  input  logic              pop,
  output sbe_pkg::sbe_out_t out_data_o
);
  import sbe_pkg::*;

  logic             op_valid;
  sbe_op_t          op;
  logic             op_deq;
  logic             halted;
  sbe_exec_status_t exec_st;

  sbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_deq_i   (op_deq),
    .halted_o   (halted)
  );

  sbe_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_deq_o   (op_deq),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .status_o   (exec_st)
  );

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(halted) |-> halted)
    else $error("halt flag dropped without reset");

  a_no_issue_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !op_valid |-> !exec_st.issue)
    else $error("execute issued with no decoded op queued");

  a_no_issue_in_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_st.fix |-> !exec_st.issue)
    else $error("execute issued during top-of-stack reload");

  a_print_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.print_valid) |->
      (out_data_o.error_code == ERR_NONE && !out_data_o.is_halted))
    else $error("print beat carries error or halt");

endmodule
